// ===== hw/rtl/mtmf_pkg.sv =====
// mtmf_pkg: constants shared by the median-then-mean adc filter
// no dependencies; imported by median_then_mean_adc_filter and its testbench
`default_nettype none

package mtmf_pkg;

    // samples per median group
    localparam int unsigned GROUP_SIZE = 3;

    // width of the sample and median counters (up to eight per gathering)
    localparam int unsigned COUNT_W = 3;

    // extra bits that a sum of up to eight values needs over one value
    localparam int unsigned SUM_EXTRA_BITS = 3;

    // extra reciprocal precision that makes floor division exact for divisors up to eight
    localparam int unsigned RECIP_EXTRA_BITS = 3;

endpackage : mtmf_pkg

`default_nettype wire

// ===== hw/rtl/median_then_mean_adc_filter.sv =====
// median_then_mean_adc_filter: start-up mean, then median of three and block mean
// depends on mtmf_pkg for the group size, counter widths and extra sum and reciprocal bits
//
// usage
//   input channel (in_valid, in_ready, raw_sample) takes one converter sample
//   per item. the first START_COUNT items after reset give one result item
//   holding their truncated mean with is_initial set. after that, every three
//   samples form a median, and every AVERAGE_COUNT medians give one result
//   item holding their truncated mean with is_initial clear. all other items
//   give no result.
//   output channel (out_valid, out_ready, filtered_value, is_initial).
// timing
//   one item per cycle sustained while in_ready is high. a result is formed
//   in two registered steps: the sum is registered in the accept cycle of
//   the item that completes it, then the reciprocal multiply fills the
//   output register once the output stage is empty or being read.
//   the two registered stages let the input keep flowing while a result waits;
//   in_ready drops only when both stages hold results and out_ready is low.
// reset
//   rst_n clears the counters, the running sum and both stage valid flags;
//   the block starts in start-up gathering.
`default_nettype none

module median_then_mean_adc_filter
    import mtmf_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS   = 12,
    parameter int unsigned START_COUNT   = 5,
    parameter int unsigned AVERAGE_COUNT = 5
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [SAMPLE_BITS-1:0] raw_sample,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [SAMPLE_BITS-1:0]      filtered_value,
    output logic                        is_initial
);

    localparam int unsigned SUM_W     = SAMPLE_BITS + SUM_EXTRA_BITS;
    localparam int unsigned DIV_SHIFT = SUM_W + RECIP_EXTRA_BITS;
    localparam int unsigned RECIP_W   = DIV_SHIFT + 1;
    localparam int unsigned PROD_W    = SUM_W + RECIP_W;

    // ceil(2^DIV_SHIFT / n) gives exact floor division for every sum below 2^SUM_W
    localparam logic [RECIP_W-1:0] START_RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(START_COUNT) - 64'd1) / 64'(START_COUNT));
    localparam logic [RECIP_W-1:0] AVERAGE_RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(AVERAGE_COUNT) - 64'd1) / 64'(AVERAGE_COUNT));

    localparam logic [COUNT_W-1:0] START_LAST   = COUNT_W'(START_COUNT - 1);
    localparam logic [COUNT_W-1:0] AVERAGE_LAST = COUNT_W'(AVERAGE_COUNT - 1);
    localparam logic [COUNT_W-1:0] GROUP_LAST   = COUNT_W'(GROUP_SIZE - 1);

    // gathering state
    logic                   warmed_up_reg,  warmed_up_next;
    logic [COUNT_W-1:0]     sample_cnt_reg, sample_cnt_next;
    logic [COUNT_W-1:0]     median_cnt_reg, median_cnt_next;
    logic [SUM_W-1:0]       acc_reg,        acc_next;
    logic [SAMPLE_BITS-1:0] group0_reg,     group0_next;
    logic [SAMPLE_BITS-1:0] group1_reg,     group1_next;

    // sum stage
    logic                   sum_valid_reg,  sum_valid_next;
    logic [SUM_W-1:0]       sum_reg,        sum_next;
    logic                   sum_init_reg,   sum_init_next;

    // output stage
    logic                   out_valid_reg,  out_valid_next;
    logic [SAMPLE_BITS-1:0] value_reg,      value_next;
    logic                   init_reg,       init_next;

    logic                   accept;
    logic                   advance;
    logic                   emit;
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;
    logic [SAMPLE_BITS-1:0] median;
    logic [SUM_W-1:0]       acc_plus_sample;
    logic [SUM_W-1:0]       acc_plus_median;
    logic [RECIP_W-1:0]     recip;
    logic [PROD_W-1:0]      product;

    assign advance  = sum_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready = ~sum_valid_reg | ~out_valid_reg | out_ready;
    assign accept   = in_valid & in_ready;

    // median of the two held samples and the incoming one
    always_comb
    begin
        lo = (group0_reg < group1_reg) ? group0_reg : group1_reg;
        hi = (group0_reg < group1_reg) ? group1_reg : group0_reg;
        if (raw_sample <= lo)
        begin
            median = lo;
        end
        else if (raw_sample >= hi)
        begin
            median = hi;
        end
        else
        begin
            median = raw_sample;
        end
    end

    assign acc_plus_sample = acc_reg + SUM_W'(raw_sample);
    assign acc_plus_median = acc_reg + SUM_W'(median);

    always_comb
    begin
        warmed_up_next  = warmed_up_reg;
        sample_cnt_next = sample_cnt_reg;
        median_cnt_next = median_cnt_reg;
        acc_next        = acc_reg;
        group0_next     = group0_reg;
        group1_next     = group1_reg;
        emit            = 1'b0;
        sum_next        = sum_reg;
        sum_init_next   = sum_init_reg;

        if (accept)
        begin
            if (!warmed_up_reg)
            begin
                if (sample_cnt_reg == START_LAST)
                begin
                    emit            = 1'b1;
                    sum_next        = acc_plus_sample;
                    sum_init_next   = 1'b1;
                    acc_next        = '0;
                    sample_cnt_next = '0;
                    warmed_up_next  = 1'b1;
                end
                else
                begin
                    acc_next        = acc_plus_sample;
                    sample_cnt_next = sample_cnt_reg + COUNT_W'(1);
                end
            end
            else if (sample_cnt_reg == GROUP_LAST)
            begin
                sample_cnt_next = '0;
                if (median_cnt_reg == AVERAGE_LAST)
                begin
                    emit            = 1'b1;
                    sum_next        = acc_plus_median;
                    sum_init_next   = 1'b0;
                    acc_next        = '0;
                    median_cnt_next = '0;
                end
                else
                begin
                    acc_next        = acc_plus_median;
                    median_cnt_next = median_cnt_reg + COUNT_W'(1);
                end
            end
            else
            begin
                if (sample_cnt_reg[0])
                begin
                    group1_next = raw_sample;
                end
                else
                begin
                    group0_next = raw_sample;
                end
                sample_cnt_next = sample_cnt_reg + COUNT_W'(1);
            end
        end
    end

    always_comb
    begin
        if (emit)
        begin
            sum_valid_next = 1'b1;
        end
        else if (advance)
        begin
            sum_valid_next = 1'b0;
        end
        else
        begin
            sum_valid_next = sum_valid_reg;
        end
    end

    // floor division by the count as a multiply by its reciprocal
    assign recip   = sum_init_reg ? START_RECIP : AVERAGE_RECIP;
    assign product = PROD_W'(sum_reg) * PROD_W'(recip);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        init_next      = init_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            value_next     = product[DIV_SHIFT +: SAMPLE_BITS];
            init_next      = sum_init_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warmed_up_reg  <= 1'b0;
            sample_cnt_reg <= '0;
            median_cnt_reg <= '0;
            acc_reg        <= '0;
            sum_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            warmed_up_reg  <= warmed_up_next;
            sample_cnt_reg <= sample_cnt_next;
            median_cnt_reg <= median_cnt_next;
            acc_reg        <= acc_next;
            sum_valid_reg  <= sum_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        group0_reg   <= group0_next;
        group1_reg   <= group1_next;
        sum_reg      <= sum_next;
        sum_init_reg <= sum_init_next;
        value_reg    <= value_next;
        init_reg     <= init_next;
    end

    assign out_valid      = out_valid_reg;
    assign filtered_value = value_reg;
    assign is_initial     = init_reg;

    // start-up mode is left once and never re-entered
    assert property (@(posedge clk) disable iff (!rst_n) !$fell(warmed_up_reg))
        else $error("warm-up flag cleared after start-up");

    // in steady mode the group counter never reaches the group size
    assert property (@(posedge clk) disable iff (!rst_n)
        warmed_up_reg |-> (sample_cnt_reg <= GROUP_LAST))
        else $error("group counter out of range");

    // a start-up sum in flight means start-up has completed
    assert property (@(posedge clk) disable iff (!rst_n)
        (sum_valid_reg && sum_init_reg) |-> warmed_up_reg)
        else $error("initial result without warm-up done");

    // medians stored never reach the averaging count
    assert property (@(posedge clk) disable iff (!rst_n)
        median_cnt_reg <= AVERAGE_LAST)
        else $error("median counter out of range");

endmodule : median_then_mean_adc_filter

`default_nettype wire

// ===== dv/tb_median_then_mean_adc_filter.sv =====
// tb_median_then_mean_adc_filter: self-checking bench for the median-then-mean adc filter
// depends on mtmf_pkg and median_then_mean_adc_filter; runs a directed table, then random
// sample groups against an in-bench filter predictor with random idling on both channels
`default_nettype none

module tb_median_then_mean_adc_filter;

    import mtmf_pkg::*;

    localparam int unsigned SAMPLE_W    = 12;
    localparam int unsigned START_N     = 5;
    localparam int unsigned AVG_N       = 5;
    localparam int unsigned STORE_DEPTH = 1 << COUNT_W;

    localparam int RAND_ITEMS  = 528;
    localparam int DRAIN_EVERY = 120;
    localparam int TAIL_CYCLES = 10;
    localparam int IDLE_LIMIT  = 1000;
    localparam int SHOW_LIMIT  = 10;

    typedef logic [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        sample_t value;
        logic    startup;
    } mean_t;

    typedef struct packed {
        sample_t sample;
        logic    typed;
        mean_t   want;
    } stim_row_t;

    localparam sample_t FULL = sample_t'((1 << SAMPLE_W) - 1);
    localparam sample_t MID  = sample_t'(1 << (SAMPLE_W - 1));

    // start-up with all ones, then five groups hitting every median ordering,
    // then one more group with alternating bit patterns
    localparam int N_ROWS = 23;
    localparam stim_row_t STIM_ROWS [N_ROWS] = '{
        '{FULL, 1'b0, '{'0, 1'b0}},
        '{FULL, 1'b0, '{'0, 1'b0}},
        '{FULL, 1'b0, '{'0, 1'b0}},
        '{FULL, 1'b0, '{'0, 1'b0}},
        '{FULL, 1'b1, '{FULL, 1'b1}},
        '{FULL, 1'b0, '{'0, 1'b0}},
        '{'0,   1'b0, '{'0, 1'b0}},
        '{MID,  1'b0, '{'0, 1'b0}},
        '{'0,   1'b0, '{'0, 1'b0}},
        '{FULL, 1'b0, '{'0, 1'b0}},
        '{FULL, 1'b0, '{'0, 1'b0}},
        '{FULL, 1'b0, '{'0, 1'b0}},
        '{FULL, 1'b0, '{'0, 1'b0}},
        '{'0,   1'b0, '{'0, 1'b0}},
        '{'0,   1'b0, '{'0, 1'b0}},
        '{'0,   1'b0, '{'0, 1'b0}},
        '{FULL, 1'b0, '{'0, 1'b0}},
        '{FULL, 1'b0, '{'0, 1'b0}},
        '{'0,   1'b0, '{'0, 1'b0}},
        '{'0,   1'b0, '{'0, 1'b0}},
        '{12'hAAA, 1'b0, '{'0, 1'b0}},
        '{12'h555, 1'b0, '{'0, 1'b0}},
        '{12'h800, 1'b0, '{'0, 1'b0}}
    };

    logic    clk;
    logic    rst_n;
    logic    in_valid;
    logic    in_ready;
    sample_t raw_sample;
    logic    out_valid;
    logic    out_ready;
    sample_t filtered_value;
    logic    is_initial;

    median_then_mean_adc_filter #(
        .SAMPLE_BITS   (SAMPLE_W),
        .START_COUNT   (START_N),
        .AVERAGE_COUNT (AVG_N)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .raw_sample     (raw_sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .filtered_value (filtered_value),
        .is_initial     (is_initial)
    );

    // filter predictor state
    logic               warm;
    logic [COUNT_W-1:0] raw_cnt;
    logic [COUNT_W-1:0] med_cnt;
    sample_t            raw_store [STORE_DEPTH];
    sample_t            med_store [STORE_DEPTH];

    mean_t expected_means [$];

    // typed expectation for the item being offered, set with the payload
    logic  typed_due;
    mean_t typed_want;

    logic src_calm;
    logic sink_calm;

    int items_taken;
    int means_due;
    int means_seen;
    int drain_pauses;
    int fault_count;
    int idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic sample_t median_of_three(input sample_t a, input sample_t b,
                                                input sample_t c);
        sample_t lo;
        sample_t hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c <= lo)
            return lo;
        if (c >= hi)
            return hi;
        return c;
    endfunction

    // advance the filter by one sample; returns 1 when a mean comes out
    function automatic bit filter_step(input sample_t s, output mean_t mean);
        logic [SAMPLE_W+SUM_EXTRA_BITS-1:0] sum;
        int i;
        mean = '0;
        sum  = '0;
        raw_store[raw_cnt] = s;
        raw_cnt = raw_cnt + 1'b1;
        if (!warm)
        begin
            if (raw_cnt == 0 || raw_cnt >= START_N)
            begin
                warm = 1'b1;
                for (i = 0; i < START_N; i++)
                    sum = sum + raw_store[i];
                mean.value   = sample_t'(sum / START_N);
                mean.startup = 1'b1;
                raw_cnt = '0;
                return 1'b1;
            end
            return 1'b0;
        end
        if (raw_cnt < GROUP_SIZE)
            return 1'b0;
        raw_cnt = '0;
        med_store[med_cnt] = median_of_three(raw_store[0], raw_store[1], raw_store[2]);
        med_cnt = med_cnt + 1'b1;
        if (med_cnt == 0 || med_cnt >= AVG_N)
        begin
            med_cnt = '0;
            for (i = 0; i < AVG_N; i++)
                sum = sum + med_store[i];
            mean.value   = sample_t'(sum / AVG_N);
            mean.startup = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void note_fault(input string msg);
        if (fault_count < SHOW_LIMIT)
            $display("[%0t] mismatch: %s", $time, msg);
        fault_count++;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        if ($urandom_range(99) < 88)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    function automatic sample_t draw_sample(input int pattern, input sample_t base);
        int v;
        if (pattern < 45)
            return sample_t'($urandom_range(FULL));
        if (pattern < 70)
        begin
            // values close together so that medians see ties
            v = int'(base) + int'($urandom_range(6)) - 3;
            if (v < 0)
                v = 0;
            if (v > int'(FULL))
                v = int'(FULL);
            return sample_t'(v);
        end
        if (pattern < 85)
            return $urandom_range(1) ? FULL : sample_t'(0);
        if ($urandom_range(1))
            return sample_t'($urandom_range(FULL, FULL - 7));
        return sample_t'($urandom_range(7));
    endfunction

    task automatic offer_sample(input sample_t s, input logic typed, input mean_t want);
        int gap;
        gap = (!src_calm && $urandom_range(99) < 30) ? gap_len() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        raw_sample <= s;
        typed_due  = typed;
        typed_want = want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain_means();
        while (expected_means.size() != 0)
            @(negedge clk);
        drain_pauses++;
    endtask

    // predictor, result checker and watchdog
    always @(posedge clk)
    begin : monitor
        mean_t pred;
        mean_t want;
        mean_t got;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                items_taken++;
                if (filter_step(raw_sample, pred))
                begin
                    expected_means.push_back(typed_due ? typed_want : pred);
                    means_due++;
                end
            end
            if (out_valid && out_ready)
            begin
                got.value   = filtered_value;
                got.startup = is_initial;
                means_seen++;
                if (expected_means.size() == 0)
                    note_fault($sformatf("result %0d/%0b with nothing expected",
                                         got.value, got.startup));
                else
                begin
                    want = expected_means.pop_front();
                    if (got.value !== want.value)
                        note_fault($sformatf("filtered_value exp %0d got %0d",
                                             want.value, got.value));
                    if (got.startup !== want.startup)
                        note_fault($sformatf("is_initial exp %0b got %0b",
                                             want.startup, got.startup));
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no item moved for %0d cycles, %0d results outstanding",
                         IDLE_LIMIT, expected_means.size());
                $display("FAIL median_then_mean_adc_filter");
                $finish;
            end
        end
    end

    // result side back-pressure
    initial
    begin : sink
        int stall;
        int phase;
        stall = 0;
        phase = 0;
        sink_calm = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (phase == 0)
            begin
                phase = $urandom_range(200, 50);
                sink_calm = ($urandom_range(3) == 0);
            end
            phase--;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else if (!sink_calm && $urandom_range(99) < 25)
            begin
                out_ready <= 1'b0;
                stall = gap_len() - 1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        int r;
        int k;
        int sent_rand;
        int pattern;
        sample_t base;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        raw_sample  = '0;
        typed_due   = 1'b0;
        typed_want  = '0;
        src_calm    = 1'b0;
        warm        = 1'b0;
        raw_cnt     = '0;
        med_cnt     = '0;
        items_taken = 0;
        means_due   = 0;
        means_seen  = 0;
        drain_pauses = 0;
        fault_count = 0;
        idle_cycles = 0;
        for (k = 0; k < STORE_DEPTH; k++)
        begin
            raw_store[k] = '0;
            med_store[k] = '0;
        end
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < N_ROWS; r++)
            offer_sample(STIM_ROWS[r].sample, STIM_ROWS[r].typed, STIM_ROWS[r].want);
        drain_means();

        sent_rand = 0;
        while (sent_rand < RAND_ITEMS)
        begin
            if (sent_rand % 60 == 0)
                src_calm = ($urandom_range(3) == 0);
            pattern = $urandom_range(99);
            base    = sample_t'($urandom_range(FULL));
            for (k = 0; k < GROUP_SIZE; k++)
                offer_sample(draw_sample(pattern, base), 1'b0, '0);
            sent_rand += GROUP_SIZE;
            if (sent_rand % DRAIN_EVERY < GROUP_SIZE)
                drain_means();
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_means.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("run covered %0d samples, %0d filtered results checked, %0d drain pauses",
                 items_taken, means_seen, drain_pauses);
        $display("mismatches counted: %0d", fault_count);
        if (fault_count == 0)
            $display("PASS median_then_mean_adc_filter");
        else
            $display("FAIL median_then_mean_adc_filter");
        $finish;
    end

endmodule : tb_median_then_mean_adc_filter

`default_nettype wire
